>>> rtl/crx_pkg.sv
// ----------------------------------------------------------------------------
// crx_pkg
// Shared types and constants of the child range expander.
// ----------------------------------------------------------------------------
package crx_pkg;

    localparam int DEF_TABLE_ENTRIES = 4096;
    localparam int DEF_MAX_RUN       = 64;

    localparam int INDEX_W = 12;
    localparam int OFFS_W  = 16;
    // run length field, wide enough for any MAX_RUN up to 127 (default 64)
    localparam int RUN_W   = 7;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_QUERY = 1'b1
    } crx_action_t;

    typedef struct packed {
        crx_action_t         action;
        logic [INDEX_W-1:0]  index;
        logic [OFFS_W-1:0]   value;
    } crx_item_t;

    typedef struct packed {
        logic [OFFS_W-1:0]   child;
        logic                last;
        logic                truncated;
        logic                bad_node;
    } crx_result_t;

    // one expansion job handed from front to back
    typedef struct packed {
        logic [OFFS_W-1:0]   base;
        logic [RUN_W-1:0]    run;
        logic                trunc;
        logic                bad;
    } crx_cmd_t;

endpackage

>>> rtl/crx_front.sv
// ----------------------------------------------------------------------------
// crx_front
// Accepts items, owns the offset table, reads both ends of a node's range
// and turns each query into an expansion job.
// ----------------------------------------------------------------------------
module crx_front #(
    parameter int TABLE_ENTRIES = crx_pkg::DEF_TABLE_ENTRIES,
    parameter int MAX_RUN       = crx_pkg::DEF_MAX_RUN
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  crx_pkg::crx_item_t  item,
    output logic                cmd_push,
    output crx_pkg::crx_cmd_t   cmd,
    input  logic                cmd_ready
);

    localparam int MAX_IDX = 1 << crx_pkg::INDEX_W;
    localparam int DEPTH   = (TABLE_ENTRIES < MAX_IDX) ? TABLE_ENTRIES : MAX_IDX;
    localparam int AW      = $clog2(DEPTH);
    localparam int CMP_W   = 17;

    logic [crx_pkg::OFFS_W-1:0] mem [DEPTH];

    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_bad_reg;
    logic [crx_pkg::OFFS_W-1:0] lo_reg;
    logic [crx_pkg::OFFS_W-1:0] hi_reg;

    logic                       accept;
    logic                       is_query;
    logic                       in_table;
    logic                       no_next;
    logic [CMP_W-1:0]           index_ext;
    logic [AW-1:0]              addr_lo;
    logic [AW-1:0]              addr_hi;
    logic [crx_pkg::OFFS_W-1:0] count;
    logic                       nonempty;
    logic                       over;
    logic                       s1_adv;

    assign index_ext = CMP_W'(item.index);
    assign in_table  = index_ext < CMP_W'(TABLE_ENTRIES);
    assign no_next   = (index_ext + CMP_W'(1)) >= CMP_W'(TABLE_ENTRIES);
    assign addr_lo   = item.index[AW-1:0];
    assign addr_hi   = addr_lo + AW'(1);
    assign is_query  = (item.action == crx_pkg::ACT_QUERY);
    assign accept    = push && !full;

    // classify the query held in stage one
    assign count    = hi_reg - lo_reg;
    assign nonempty = hi_reg > lo_reg;
    assign over     = CMP_W'(count) > CMP_W'(MAX_RUN);

    always_comb
    begin
        cmd_push  = s1_valid_reg && (s1_bad_reg || nonempty);
        cmd.base  = s1_bad_reg ? '0 : lo_reg;
        cmd.bad   = s1_bad_reg;
        cmd.trunc = !s1_bad_reg && over;
        if (s1_bad_reg)
        begin
            cmd.run = crx_pkg::RUN_W'(1);
        end
        else if (over)
        begin
            cmd.run = crx_pkg::RUN_W'(MAX_RUN);
        end
        else
        begin
            cmd.run = count[crx_pkg::RUN_W-1:0];
        end
    end

    // drop empty ranges, hold when the job queue is full
    assign s1_adv = !cmd_push || cmd_ready;
    assign full   = s1_valid_reg && !s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept && is_query)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !is_query && in_table)
        begin
            mem[addr_lo] <= item.value;
        end
        if (accept && is_query)
        begin
            s1_bad_reg <= no_next;
            if (!no_next)
            begin
                lo_reg <= mem[addr_lo];
                hi_reg <= mem[addr_hi];
            end
        end
    end

endmodule

>>> rtl/crx_cmd_queue.sv
// ----------------------------------------------------------------------------
// crx_cmd_queue
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module crx_cmd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  crx_pkg::crx_cmd_t  wr_cmd,
    output logic               wr_ready,
    output logic               rd_valid,
    output crx_pkg::crx_cmd_t  rd_cmd,
    input  logic               rd_en
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    crx_pkg::crx_cmd_t entry [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_wr;
    logic          do_rd;

    assign wr_ready = cnt_reg != CW'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_cmd   = entry[rd_ptr_reg];
    assign do_wr    = wr_en && wr_ready;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

>>> rtl/crx_back.sv
// ----------------------------------------------------------------------------
// crx_back
// Expands one job into consecutive child results in a result register, one
// per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module crx_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  crx_pkg::crx_cmd_t    cmd,
    output logic                 cmd_take,
    output logic                 empty,
    input  logic                 pop,
    output crx_pkg::crx_result_t result
);

    logic                       act_reg, act_next;
    logic [crx_pkg::OFFS_W-1:0] base_reg, base_next;
    logic [crx_pkg::RUN_W-1:0]  left_reg, left_next;
    logic                       trunc_reg, trunc_next;
    logic                       bad_reg, bad_next;
    logic                       out_valid_reg, out_valid_next;
    crx_pkg::crx_result_t       out_reg, out_next;

    logic out_free;
    logic emit;
    logic ending;

    assign out_free = !out_valid_reg || pop;
    assign emit     = act_reg && out_free;
    assign ending   = emit && (left_reg == crx_pkg::RUN_W'(1));
    assign cmd_take = cmd_valid && (!act_reg || ending);
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_comb
    begin
        act_next   = act_reg;
        base_next  = base_reg;
        left_next  = left_reg;
        trunc_next = trunc_reg;
        bad_next   = bad_reg;
        if (cmd_take)
        begin
            act_next   = 1'b1;
            base_next  = cmd.base;
            left_next  = cmd.run;
            trunc_next = cmd.trunc;
            bad_next   = cmd.bad;
        end
        else if (ending)
        begin
            act_next = 1'b0;
        end
        else if (emit)
        begin
            base_next = base_reg + crx_pkg::OFFS_W'(1);
            left_next = left_reg - crx_pkg::RUN_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next     = 1'b1;
            out_next.child     = base_reg;
            out_next.last      = ending;
            out_next.truncated = ending && trunc_reg;
            out_next.bad_node  = bad_reg;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            act_reg       <= act_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        left_reg  <= left_next;
        trunc_reg <= trunc_next;
        bad_reg   <= bad_next;
        out_reg   <= out_next;
    end

endmodule

>>> rtl/child_range_expander.sv
// ----------------------------------------------------------------------------
// child_range_expander
// Split-offset child expansion: stores a first-child offset per node and
// lists the children of a queried node in ascending order.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake          Payload        Moves
//  --------  -----------------  -------------  ------------------------------
//  input     push / full        item           write entry or node query
//  result    pop / empty        result         one child, last/trunc/bad flags
//
//  The front takes one item per cycle while the query in its read stage can
//  move on; a query's read stage fetches both ends of its range from one
//  dual-read port, then the back emits one child per cycle while the result
//  register is free or popped; a query yields run = min(offset[k+1]-offset[k],
//  MAX_RUN) children, or one for a bad node. Writes and empty ranges send no
//  job to the back. Reset clears control only: the table is undefined until
//  written, and no clearing pass runs. Each side stalls on its own through
//  the two-entry job queue and the result register.
//
module child_range_expander #(
    parameter int TABLE_ENTRIES = crx_pkg::DEF_TABLE_ENTRIES,
    parameter int MAX_RUN       = crx_pkg::DEF_MAX_RUN
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  crx_pkg::crx_item_t   item,
    output logic                 empty,
    input  logic                 pop,
    output crx_pkg::crx_result_t result
);

    // front to queue
    logic              f_push;
    crx_pkg::crx_cmd_t f_cmd;
    logic              q_ready;
    // queue to back
    logic              q_valid;
    crx_pkg::crx_cmd_t q_cmd;
    logic              b_take;

    // Accept items, write the table, read and classify ranges.
    crx_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_RUN       (MAX_RUN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_push  (f_push),
        .cmd       (f_cmd),
        .cmd_ready (q_ready)
    );

    // Decouple the table side from the result side.
    crx_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (f_push),
        .wr_cmd   (f_cmd),
        .wr_ready (q_ready),
        .rd_valid (q_valid),
        .rd_cmd   (q_cmd),
        .rd_en    (b_take)
    );

    // Walk each range and present one result per transfer.
    crx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_take  (b_take),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

>>> rtl/crx_checker.sv
// ----------------------------------------------------------------------------
// crx_checker
// Port-level checks of the child range expander, bound to the top level.
// ----------------------------------------------------------------------------
module crx_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 push,
    input logic                 full,
    input crx_pkg::crx_item_t   item,
    input logic                 empty,
    input logic                 pop,
    input crx_pkg::crx_result_t result
);

    // a waiting result holds until its transfer
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed or vanished while stalled");

    // a bad-node result stands alone with a zero child
    a_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.bad_node) |-> (result.last && !result.truncated
                                         && (result.child == '0)))
        else $error("malformed bad-node result");

    // truncation is flagged only on the final result
    a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.truncated) |-> result.last)
        else $error("truncated set on a non-final result");

    // children of one query are consecutive
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !result.last) |=>
            (empty || (result.child == $past(result.child) + 16'd1)))
        else $error("child indices not consecutive within a query");

endmodule

bind child_range_expander crx_checker u_crx_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
